// File: rtl/wsi_pkg.sv
package wsi_pkg;

  localparam int unsigned LANES      = 4;
  localparam int unsigned MAX_MODELS = 4;
  localparam int unsigned LANE_LIMIT = (MAX_MODELS < LANES) ? MAX_MODELS : LANES;

  localparam int unsigned SCORE_W  = 16;
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned LN_W     = 24;  // Q.16 log value, signed
  localparam int unsigned EXP_W    = 31;  // Q.30, at most 1.0
  localparam int unsigned DIFF_W   = 23;  // Q.16 exponent distance
  localparam int unsigned TERM_W   = 48;
  localparam int unsigned SUM_W    = 50;

  localparam logic [16:0] LN2_Q16  = 17'd45426;
  localparam logic [16:0] INV_LN2  = 17'd94548;  // floor(2^32 / LN2_Q16)
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [8:0]  EXP_SHIFT_MAX = 9'd40;

  localparam logic [5:0] FRAC_WEIGHT = 6'd16;
  localparam logic [5:0] FRAC_LSE    = 6'd30;
  localparam logic [5:0] FRAC_LIN    = 6'd46;

  localparam logic [1:0] MODE_LSE = 2'd0;
  localparam logic [1:0] MODE_DOT = 2'd1;
  localparam logic [1:0] MODE_LIN = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_MODELS = 3'd1;
  localparam logic [2:0] REG_W0     = 3'd2;
  localparam logic [2:0] REG_W1     = 3'd3;
  localparam logic [2:0] REG_W2     = 3'd4;
  localparam logic [2:0] REG_W3     = 3'd5;

  // ln(1 + 2^-(idx+1)) in Q.16
  function automatic logic [14:0] ln_step(input logic [3:0] idx);
    logic [14:0] r;
    case (idx)
      4'd0:    r = 15'd26573;
      4'd1:    r = 15'd14624;
      4'd2:    r = 15'd7719;
      4'd3:    r = 15'd3973;
      4'd4:    r = 15'd2017;
      4'd5:    r = 15'd1016;
      4'd6:    r = 15'd510;
      4'd7:    r = 15'd256;
      4'd8:    r = 15'd128;
      4'd9:    r = 15'd64;
      4'd10:   r = 15'd32;
      4'd11:   r = 15'd16;
      4'd12:   r = 15'd8;
      4'd13:   r = 15'd4;
      4'd14:   r = 15'd2;
      default: r = 15'd1;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/wsi_ln.sv
module wsi_ln #(
  parameter int unsigned W = 17
) (
  input  logic                                clk_i,
  input  logic [W-1:0]                        v_i,
  input  logic [5:0]                          frac_i,
  output logic signed [wsi_pkg::LN_W-1:0]     y_o
);

  localparam int unsigned BW     = $clog2(W);
  localparam int unsigned GROUPS = 4;
  localparam int unsigned STEPS  = 4;

  logic [W-1:0]  v_q;
  logic [BW-1:0] b_d, b_q;
  logic [5:0]    frac_q;

  always_comb begin
    b_d = '0;
    for (int i = 1; i < W; i++) begin
      if (v_i[i]) begin
        b_d = BW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_i;
    b_q    <= b_d;
    frac_q <= frac_i;
  end

  // normalize to [1,2) in Q.30
  logic [W+29:0]      vx;
  logic [30:0]        x1_q;
  logic signed [7:0]  e1_q;

  assign vx = {v_q, 30'd0};

  always_ff @(posedge clk_i) begin
    x1_q <= 31'(vx >> b_q);
    e1_q <= $signed({1'b0, 7'(b_q)}) - $signed({2'b0, frac_q});
  end

  logic [31:0]       p_q [GROUPS];
  logic [15:0]       y_q [GROUPS];
  logic [30:0]       x_q [GROUPS];
  logic signed [7:0] e_q [GROUPS];

  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    logic [31:0]       p_in, p_n;
    logic [15:0]       y_in, y_n;
    logic [30:0]       x_in;
    logic signed [7:0] e_in;

    if (g == 0) begin : g_first
      assign p_in = {1'b0, wsi_pkg::ONE_Q30};
      assign y_in = '0;
      assign x_in = x1_q;
      assign e_in = e1_q;
    end else begin : g_next
      assign p_in = p_q[g-1];
      assign y_in = y_q[g-1];
      assign x_in = x_q[g-1];
      assign e_in = e_q[g-1];
    end

    always_comb begin
      logic [31:0] t;
      p_n = p_in;
      y_n = y_in;
      for (int j = 0; j < STEPS; j++) begin
        t = p_n + (p_n >> (g * STEPS + j + 1));
        if (t <= {1'b0, x_in}) begin
          p_n = t;
          y_n = y_n + 16'(wsi_pkg::ln_step(4'(g * STEPS + j)));
        end
      end
    end

    always_ff @(posedge clk_i) begin
      p_q[g] <= p_n;
      y_q[g] <= y_n;
      x_q[g] <= x_in;
      e_q[g] <= e_in;
    end
  end

  logic [31:0]        rem;
  logic signed [25:0] eln;
  logic signed [wsi_pkg::LN_W-1:0] y_d;

  assign rem = {1'b0, x_q[GROUPS-1]} - p_q[GROUPS-1];
  assign eln = e_q[GROUPS-1] * $signed({1'b0, wsi_pkg::LN2_Q16});
  assign y_d = $signed(wsi_pkg::LN_W'(y_q[GROUPS-1]))
             + $signed(wsi_pkg::LN_W'(rem[31:14]))
             + wsi_pkg::LN_W'(eln);

  always_ff @(posedge clk_i) begin
    y_o <= y_d;
  end

endmodule

// File: rtl/wsi_exp.sv
module wsi_exp (
  input  logic                           clk_i,
  input  logic [wsi_pkg::DIFF_W-1:0]     d_i,
  output logic [wsi_pkg::EXP_W-1:0]      e_o
);

  localparam int unsigned GROUPS = 4;
  localparam int unsigned STEPS  = 4;

  // d = q*ln2 + r, reciprocal estimate then one correction
  logic [39:0] qprod;
  logic [7:0]  q0_q;
  logic [22:0] d0_q;
  logic        z0_q;

  assign qprod = 40'(d_i) * 40'(wsi_pkg::INV_LN2);

  always_ff @(posedge clk_i) begin
    q0_q <= qprod[39:32];
    d0_q <= d_i;
    z0_q <= (d_i == '0);
  end

  logic [23:0] qm;
  logic [23:0] r1_full;
  logic [16:0] r1_q;
  logic [7:0]  q1_q;
  logic        z1_q;

  assign qm      = 24'(q0_q) * 24'(wsi_pkg::LN2_Q16);
  assign r1_full = 24'(d0_q) - qm;

  always_ff @(posedge clk_i) begin
    r1_q <= r1_full[16:0];
    q1_q <= q0_q;
    z1_q <= z0_q;
  end

  logic [16:0] r2;
  logic [7:0]  q2;
  logic [15:0] a2_q;
  logic [7:0]  q2_q;
  logic        z2_q;

  always_comb begin
    if (r1_q >= wsi_pkg::LN2_Q16) begin
      r2 = r1_q - wsi_pkg::LN2_Q16;
      q2 = q1_q + 8'd1;
    end else begin
      r2 = r1_q;
      q2 = q1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a2_q <= 16'(wsi_pkg::LN2_Q16 - r2);
    q2_q <= q2;
    z2_q <= z1_q;
  end

  logic [31:0] p_q [GROUPS];
  logic [15:0] a_q [GROUPS];
  logic [7:0]  q_q [GROUPS];
  logic        z_q [GROUPS];

  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    logic [31:0] p_in, p_n;
    logic [15:0] a_in, a_n;
    logic [7:0]  q_in;
    logic        z_in;

    if (g == 0) begin : g_first
      assign p_in = {1'b0, wsi_pkg::ONE_Q30};
      assign a_in = a2_q;
      assign q_in = q2_q;
      assign z_in = z2_q;
    end else begin : g_next
      assign p_in = p_q[g-1];
      assign a_in = a_q[g-1];
      assign q_in = q_q[g-1];
      assign z_in = z_q[g-1];
    end

    always_comb begin
      logic [15:0] st;
      p_n = p_in;
      a_n = a_in;
      for (int j = 0; j < STEPS; j++) begin
        st = 16'(wsi_pkg::ln_step(4'(g * STEPS + j)));
        if (st <= a_n) begin
          a_n = a_n - st;
          p_n = p_n + (p_n >> (g * STEPS + j + 1));
        end
      end
    end

    always_ff @(posedge clk_i) begin
      p_q[g] <= p_n;
      a_q[g] <= a_n;
      q_q[g] <= q_in;
      z_q[g] <= z_in;
    end
  end

  logic [47:0] pa;
  logic [32:0] p7_q;
  logic [7:0]  q7_q;
  logic        z7_q;

  assign pa = 48'(p_q[GROUPS-1]) * 48'(a_q[GROUPS-1]);

  always_ff @(posedge clk_i) begin
    p7_q <= 33'(p_q[GROUPS-1]) + 33'(pa[47:16]);
    q7_q <= q_q[GROUPS-1];
    z7_q <= z_q[GROUPS-1];
  end

  logic [8:0]  sh;
  logic [32:0] ps;
  logic [30:0] e_d;

  assign sh = 9'(q7_q) + 9'd1;
  assign ps = p7_q >> sh;

  always_comb begin
    if (z7_q) begin
      e_d = wsi_pkg::ONE_Q30;
    end else if (sh >= wsi_pkg::EXP_SHIFT_MAX) begin
      e_d = '0;
    end else if (ps > 33'(wsi_pkg::ONE_Q30)) begin
      e_d = wsi_pkg::ONE_Q30;
    end else begin
      e_d = ps[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    e_o <= e_d;
  end

endmodule

// File: rtl/weighted_score_interpolator.sv
// Channel   Direction  Ports                                        Handshake
// config    in         cfg_index_i, cfg_data_i                      cfg_valid_i / cfg_ready_o
// item      in         score_lane0_i .. score_lane3_i               start / busy
// result    out        combined_score_o, status_o                   result_valid_o strobe
//
// One item is accepted every cycle; busy stays low.
// Each item passes, in series, the score delay line beside the weight log unit,
// the lane exp units and the final log unit. Results leave in order.
// Reset clears the valid pipeline and loads the register defaults.
// The receiver cannot stall; nothing in the pipeline ever waits.
module weighted_score_interpolator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [16:0]         cfg_data_i,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  score_lane0_i,
  input  logic signed [15:0]  score_lane1_i,
  input  logic signed [15:0]  score_lane2_i,
  input  logic signed [15:0]  score_lane3_i,
  output logic                result_valid_o,
  output logic signed [15:0]  combined_score_o,
  output logic [1:0]          status_o
);

  localparam int unsigned L       = wsi_pkg::LANES;
  localparam int unsigned VLD_LEN = 27;
  localparam int unsigned SIDE_LEN = 18;
  localparam int unsigned Z_LEN   = 7;
  localparam int unsigned RESULT_LAT = 28;

  typedef struct packed {
    logic signed [23:0] base;
    logic signed [19:0] dot;
    logic [3:0]         valid;
    logic [1:0]         best;
    logic               any;
  } side_t;

  // configuration
  logic [1:0]  mode_q;
  logic [2:0]  models_q;
  logic [16:0] weight_q [L];

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= wsi_pkg::MODE_LSE;
      models_q    <= 3'd1;
      weight_q[0] <= 17'h10000;
      weight_q[1] <= '0;
      weight_q[2] <= '0;
      weight_q[3] <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        wsi_pkg::REG_MODE:   mode_q      <= cfg_data_i[1:0];
        wsi_pkg::REG_MODELS: models_q    <= cfg_data_i[2:0];
        wsi_pkg::REG_W0:     weight_q[0] <= cfg_data_i;
        wsi_pkg::REG_W1:     weight_q[1] <= cfg_data_i;
        wsi_pkg::REG_W2:     weight_q[2] <= cfg_data_i;
        wsi_pkg::REG_W3:     weight_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic is_dot, is_lin, is_lse;
  assign is_dot = (mode_q == wsi_pkg::MODE_DOT);
  assign is_lin = (mode_q == wsi_pkg::MODE_LIN);
  assign is_lse = !is_dot && !is_lin;

  logic [2:0] n_lanes;
  logic [L-1:0] lane_en;

  always_comb begin
    if (models_q == 3'd0) begin
      n_lanes = 3'd1;
    end else if (models_q > 3'(wsi_pkg::LANE_LIMIT)) begin
      n_lanes = 3'(wsi_pkg::LANE_LIMIT);
    end else begin
      n_lanes = models_q;
    end
    for (int i = 0; i < L; i++) begin
      lane_en[i] = (3'(i) < n_lanes);
    end
  end

  // valid pipeline
  logic accept;
  logic [VLD_LEN-1:0] vld_q;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[VLD_LEN-2:0], accept};
    end
  end

  // score delay line
  logic signed [15:0] s_in [L];
  logic signed [15:0] sline_q [9][L];

  assign s_in[0] = score_lane0_i;
  assign s_in[1] = score_lane1_i;
  assign s_in[2] = score_lane2_i;
  assign s_in[3] = score_lane3_i;

  always_ff @(posedge clk_i) begin
    sline_q[0] <= s_in;
    for (int j = 1; j < 9; j++) begin
      sline_q[j] <= sline_q[j-1];
    end
  end

  // lane log of weights
  logic signed [23:0] lnw [L];

  for (genvar i = 0; i < L; i++) begin : g_lnw
    wsi_ln #(.W(wsi_pkg::WEIGHT_W)) u_ln (
      .clk_i  (clk_i),
      .v_i    (weight_q[i]),
      .frac_i (wsi_pkg::FRAC_WEIGHT),
      .y_o    (lnw[i])
    );
  end

  logic signed [23:0] lv_q [L];
  logic [L-1:0]       val_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < L; i++) begin
      lv_q[i]  <= lnw[i] + $signed({{2{sline_q[6][i][15]}}, sline_q[6][i], 6'd0});
      val_q[i] <= lane_en[i] && (weight_q[i] != '0);
    end
  end

  // merge: largest term, largest score, dot products
  logic signed [23:0] bestlv_d, bestlv_q;
  logic [1:0]         best_d, best_q;
  logic               any_d, any_q;
  logic signed [15:0] m_d, m_q;
  logic signed [23:0] lv8_q [L];
  logic [L-1:0]       val8_q;
  logic signed [33:0] prod_q [L];

  always_comb begin
    bestlv_d = '0;
    best_d   = '0;
    any_d    = 1'b0;
    m_d      = sline_q[7][0];
    for (int i = 0; i < L; i++) begin
      if (val_q[i] && (!any_d || lv_q[i] > bestlv_d)) begin
        bestlv_d = lv_q[i];
        best_d   = 2'(i);
        any_d    = 1'b1;
      end
      if (lane_en[i] && sline_q[7][i] > m_d) begin
        m_d = sline_q[7][i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bestlv_q <= bestlv_d;
    best_q   <= best_d;
    any_q    <= any_d;
    m_q      <= m_d;
    lv8_q    <= lv_q;
    val8_q   <= val_q;
    for (int i = 0; i < L; i++) begin
      prod_q[i] <= lane_en[i] ? sline_q[7][i] * $signed({1'b0, weight_q[i]}) : 34'sd0;
    end
  end

  // lane exp distances
  logic [22:0]        d [L];
  logic [30:0]        e [L];
  logic signed [16:0] sdiff [L];
  logic signed [23:0] ldiff [L];

  always_comb begin
    for (int i = 0; i < L; i++) begin
      sdiff[i] = 17'(m_q) - 17'(sline_q[8][i]);
      ldiff[i] = bestlv_q - lv8_q[i];
      if (is_lin) begin
        d[i] = lane_en[i] ? 23'({sdiff[i][15:0], 6'd0}) : '0;
      end else begin
        d[i] = val8_q[i] ? ldiff[i][22:0] : '0;
      end
    end
  end

  for (genvar i = 0; i < L; i++) begin : g_exp
    wsi_exp u_exp (
      .clk_i (clk_i),
      .d_i   (d[i]),
      .e_o   (e[i])
    );
  end

  // side data travels beside the exp and log units
  side_t              side_d;
  side_t              side_q [SIDE_LEN];
  logic signed [35:0] dsum;

  assign dsum = 36'(prod_q[0]) + 36'(prod_q[1]) + 36'(prod_q[2]) + 36'(prod_q[3]);

  always_comb begin
    side_d.base  = is_lin ? $signed({{2{m_q[15]}}, m_q, 6'd0}) : bestlv_q;
    side_d.dot   = 20'((dsum + 36'sd32768) >>> 16);
    side_d.valid = val8_q;
    side_d.best  = best_q;
    side_d.any   = any_q;
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int j = 1; j < SIDE_LEN; j++) begin
      side_q[j] <= side_q[j-1];
    end
  end

  // merge: weighted sum of exp terms
  logic [47:0] term_q [L];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < L; i++) begin
      if (is_lin) begin
        term_q[i] <= lane_en[i] ? 48'(weight_q[i]) * 48'(e[i]) : '0;
      end else begin
        term_q[i] <= (side_q[8].valid[i] && side_q[8].best != 2'(i)) ? 48'(e[i]) : '0;
      end
    end
  end

  logic [49:0] sa_q, sb_q, arg;

  always_ff @(posedge clk_i) begin
    sa_q <= 50'(term_q[0]) + 50'(term_q[1]);
    sb_q <= 50'(term_q[2]) + 50'(term_q[3]) + (is_lin ? 50'd0 : 50'(wsi_pkg::ONE_Q30));
  end

  assign arg = sa_q + sb_q;

  logic signed [23:0] lnsum;

  wsi_ln #(.W(wsi_pkg::SUM_W)) u_ln_sum (
    .clk_i  (clk_i),
    .v_i    (arg),
    .frac_i (is_lin ? wsi_pkg::FRAC_LIN : wsi_pkg::FRAC_LSE),
    .y_o    (lnsum)
  );

  logic [Z_LEN-1:0] zline_q;

  always_ff @(posedge clk_i) begin
    zline_q <= {zline_q[Z_LEN-2:0], (arg == '0)};
  end

  // final rounding, saturation and status
  side_t              side_f;
  logic signed [24:0] vsum;
  logic signed [24:0] vrnd;
  logic signed [19:0] res;
  logic               zero;
  logic signed [15:0] score_d;
  logic [1:0]         status_d;

  assign side_f = side_q[SIDE_LEN-1];
  assign vsum   = 25'(side_f.base) + 25'(lnsum) + 25'sd32;
  assign vrnd   = vsum >>> 6;

  always_comb begin
    res  = is_dot ? side_f.dot : 20'(vrnd);
    zero = is_lse ? !side_f.any : (is_lin && zline_q[Z_LEN-1]);
    if (zero) begin
      score_d  = -16'sd32768;
      status_d = wsi_pkg::ST_ZERO;
    end else if (res > 20'sd32767) begin
      score_d  = 16'sd32767;
      status_d = wsi_pkg::ST_SAT;
    end else if (res < -20'sd32768) begin
      score_d  = -16'sd32768;
      status_d = wsi_pkg::ST_SAT;
    end else begin
      score_d  = 16'(res);
      status_d = wsi_pkg::ST_OK;
    end
  end

  logic               rv_q;
  logic signed [15:0] score_q;
  logic [1:0]         status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= vld_q[VLD_LEN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    score_q  <= score_d;
    status_q <= status_d;
  end

  assign result_valid_o   = rv_q;
  assign combined_score_o = score_q;
  assign status_o         = status_q;

  a_item_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##RESULT_LAT result_valid_o)
    else $error("item without result");

  a_result_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, RESULT_LAT))
    else $error("result without item");

  a_zero_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == wsi_pkg::ST_ZERO) |-> combined_score_o == -16'sd32768)
    else $error("zero sum with wrong score");

  a_sat_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == wsi_pkg::ST_SAT) |->
      (combined_score_o == 16'sd32767 || combined_score_o == -16'sd32768))
    else $error("saturated status with unsaturated score");

endmodule

// File: bench/tb_weighted_score_interpolator.sv
module tb_weighted_score_interpolator;

  typedef logic signed [15:0] lane_vec_t [4];
  typedef logic [16:0] weight_vec_t [4];

  typedef struct {
    logic signed [15:0] score;
    logic [1:0]         status;
  } outcome_t;

  typedef struct {
    logic [1:0]         mode;
    logic [2:0]         models;
    int unsigned        w[4];
    int                 s[4];
    bit                 typed;
    int                 exp_score;
    logic [1:0]         exp_status;
  } row_t;

  localparam logic [1:0] M_LSE  = wsi_pkg::MODE_LSE;
  localparam logic [1:0] M_DOT  = wsi_pkg::MODE_DOT;
  localparam logic [1:0] M_LIN  = wsi_pkg::MODE_LIN;
  localparam logic [1:0] S_OK   = wsi_pkg::ST_OK;
  localparam logic [1:0] S_ZERO = wsi_pkg::ST_ZERO;
  localparam logic [1:0] S_SAT  = wsi_pkg::ST_SAT;

  localparam int unsigned LN_TBL[16] = '{26573, 14624, 7719, 3973, 2017, 1016, 510, 256,
                                         128, 64, 32, 16, 8, 4, 2, 1};
  localparam longint LN2 = 45426;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_PHASES = 14;
  localparam int PHASE_ITEMS = 125;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [16:0]        cfg_data_i;
  logic               start;
  logic               busy;
  logic signed [15:0] score_lane0_i, score_lane1_i, score_lane2_i, score_lane3_i;
  logic               result_valid_o;
  logic signed [15:0] combined_score_o;
  logic [1:0]         status_o;

  weighted_score_interpolator dut (.*);

  always #10 clk_i = ~clk_i;

  // register copy used by the predictor
  logic [1:0]  cur_mode;
  logic [2:0]  cur_models;
  weight_vec_t cur_w;

  outcome_t pending_q[$];
  int       errors;
  int       quiet_cycles;
  bit       use_typed;
  outcome_t typed_out;
  bit       idle_on;

  function automatic longint ln_q16(longint unsigned v, int frac);
    int b;
    int k;
    longint unsigned x, p, t;
    longint y;
    b = 63;
    p = 64'd1 << 30;
    y = 0;
    while (b > 0 && ((v >> b) & 1) == 0) b--;
    x = (b >= 30) ? (v >> (b - 30)) : (v << (30 - b));
    for (k = 1; k <= 16; k++) begin
      t = p + (p >> k);
      if (t <= x) begin
        p = t;
        y += LN_TBL[k-1];
      end
    end
    y += longint'((x - p) >> 14);
    return y + longint'(b - frac) * LN2;
  endfunction

  function automatic longint unsigned exp_neg_q30(longint unsigned d);
    int k;
    longint unsigned q, a, p;
    p = 64'd1 << 30;
    if (d == 0) return p;
    q = d / LN2;
    a = LN2 - (d - q * LN2);
    for (k = 1; k <= 16; k++) begin
      if (LN_TBL[k-1] <= a) begin
        a -= LN_TBL[k-1];
        p += p >> k;
      end
    end
    p += (p * a) >> 16;
    if (q + 1 >= 40) return 0;
    p = p >> (q + 1);
    return (p > (64'd1 << 30)) ? (64'd1 << 30) : p;
  endfunction

  function automatic longint div_half_up(longint v, longint d);
    longint t;
    t = v + d / 2;
    if (t >= 0) return t / d;
    return -((-t + d - 1) / d);
  endfunction

  function automatic outcome_t interpolate(lane_vec_t sc);
    outcome_t o;
    longint s[4], lv[4], w[4];
    longint res, m, acc;
    longint unsigned tot, uacc;
    int n, i, best;
    bit zero;
    res = 0;
    zero = 0;
    n = cur_models;
    if (n > 4) n = 4;
    if (n < 1) n = 1;
    for (i = 0; i < 4; i++) begin
      s[i] = sc[i];
      w[i] = cur_w[i];
    end
    if (cur_mode == M_DOT) begin
      acc = 0;
      for (i = 0; i < n; i++) acc += s[i] * w[i];
      res = div_half_up(acc, 65536);
    end else if (cur_mode == M_LIN) begin
      m = s[0];
      tot = 0;
      for (i = 1; i < n; i++) if (s[i] > m) m = s[i];
      for (i = 0; i < n; i++) tot += w[i] * exp_neg_q30((m - s[i]) * 64);
      if (tot == 0) zero = 1;
      else res = div_half_up(m * 64 + ln_q16(tot, 46), 64);
    end else begin
      best = -1;
      for (i = 0; i < n; i++) begin
        if (w[i] == 0) continue;
        lv[i] = ln_q16(w[i], 16) + s[i] * 64;
        if (best < 0 || lv[i] > lv[best]) best = i;
      end
      if (best < 0) zero = 1;
      else begin
        uacc = 0;
        for (i = 0; i < n; i++)
          if (i != best && w[i] != 0) uacc += exp_neg_q30(lv[best] - lv[i]);
        res = div_half_up(lv[best] + ln_q16((64'd1 << 30) + uacc, 30), 64);
      end
    end
    o.status = S_OK;
    if (zero) begin
      res = -32768;
      o.status = S_ZERO;
    end else if (res > 32767) begin
      res = 32767;
      o.status = S_SAT;
    end else if (res < -32768) begin
      res = -32768;
      o.status = S_SAT;
    end
    o.score = res[15:0];
    return o;
  endfunction

  always @(posedge clk_i) begin
    lane_vec_t sc;
    outcome_t got, want;
    bit active;
    active = 0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        active = 1;
        case (cfg_index_i)
          wsi_pkg::REG_MODE:   cur_mode   = cfg_data_i[1:0];
          wsi_pkg::REG_MODELS: cur_models = cfg_data_i[2:0];
          wsi_pkg::REG_W0:     cur_w[0]   = cfg_data_i;
          wsi_pkg::REG_W1:     cur_w[1]   = cfg_data_i;
          wsi_pkg::REG_W2:     cur_w[2]   = cfg_data_i;
          wsi_pkg::REG_W3:     cur_w[3]   = cfg_data_i;
          default: ;
        endcase
      end
      if (start && !busy) begin
        active = 1;
        sc = '{score_lane0_i, score_lane1_i, score_lane2_i, score_lane3_i};
        pending_q.insert(pending_q.size(), use_typed ? typed_out : interpolate(sc));
      end
      if (result_valid_o) begin
        active = 1;
        got.score = combined_score_o;
        got.status = status_o;
        if (pending_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result score=%0d status=%0d", $time,
                   got.score, got.status);
        end else begin
          want = pending_q.pop_front();
          if (got.score !== want.score) begin
            errors++;
            $display("%0t: combined_score expected %0d actual %0d", $time,
                     want.score, got.score);
          end
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, got.status);
          end
        end
      end
    end
    quiet_cycles = active ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [1:0] md, logic [2:0] nm, weight_vec_t w);
    logic [16:0] vals[6];
    int i;
    vals = '{{15'd0, md}, {14'd0, nm}, w[0], w[1], w[2], w[3]};
    wait_drained();
    for (i = 0; i < 6; i++) begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        @(negedge clk_i) cfg_valid_i <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk_i);
      end
      @(negedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= i[2:0];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  task automatic send_item(lane_vec_t sc, bit typed, outcome_t tout);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i) start <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
    @(negedge clk_i);
    use_typed = typed;
    typed_out = tout;
    start <= 1'b1;
    score_lane0_i <= sc[0];
    score_lane1_i <= sc[1];
    score_lane2_i <= sc[2];
    score_lane3_i <= sc[3];
    do @(posedge clk_i); while (busy);
  endtask

  function automatic logic [16:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      3: return 17'($urandom);
      default: return 17'($urandom_range(1, 65536));
    endcase
  endfunction

  function automatic logic signed [15:0] clip16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic lane_vec_t pick_scores();
    lane_vec_t sc;
    int base, span, i;
    base = $signed(16'($urandom));
    span = 1 << $urandom_range(4, 13);
    for (i = 0; i < 4; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    sc[i] = 16'($urandom);
        2:       sc[i] = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        default: sc[i] = clip16(base + $urandom_range(0, 2 * span) - span);
      endcase
    end
    return sc;
  endfunction

  row_t dir_tbl[] = '{
    '{M_LSE, 3'd1, '{65536, 0, 0, 0}, '{0, 5, 6, 7}, 1, 0, S_OK},
    '{M_LSE, 3'd1, '{65536, 0, 0, 0}, '{32767, 0, 0, 0}, 1, 32767, S_OK},
    '{M_LSE, 3'd1, '{65536, 0, 0, 0}, '{-32768, 9, 9, 9}, 1, -32768, S_OK},
    '{M_LSE, 3'd1, '{65536, 0, 0, 0}, '{1234, -7, 32767, -32768}, 1, 1234, S_OK},
    '{M_LSE, 3'd1, '{131071, 0, 0, 0}, '{32767, 0, 0, 0}, 1, 32767, S_SAT},
    '{M_LSE, 3'd1, '{131071, 0, 0, 0}, '{-32768, 0, 0, 0}, 0, 0, S_OK},
    '{M_DOT, 3'd4, '{65536, 65536, 65536, 65536}, '{32767, 32767, 32767, 32767},
      1, 32767, S_SAT},
    '{M_DOT, 3'd4, '{65536, 65536, 65536, 65536}, '{-32768, -32768, -32768, -32768},
      1, -32768, S_SAT},
    '{M_DOT, 3'd4, '{65536, 65536, 65536, 65536}, '{100, 200, -50, 7}, 1, 257, S_OK},
    '{M_DOT, 3'd4, '{131071, 1, 32768, 0}, '{-1, 3, 1, 32767}, 0, 0, S_OK},
    '{M_LSE, 3'd4, '{0, 0, 0, 0}, '{10, 20, 30, 40}, 1, -32768, S_ZERO},
    '{M_LIN, 3'd4, '{0, 0, 0, 0}, '{10, 20, 30, 40}, 1, -32768, S_ZERO},
    '{M_LIN, 3'd2, '{0, 65536, 0, 0}, '{32767, -32768, 0, 0}, 1, -32768, S_ZERO},
    '{M_LIN, 3'd4, '{65536, 65536, 65536, 65536}, '{500, 500, 500, 500}, 0, 0, S_OK},
    '{M_LIN, 3'd4, '{65536, 65536, 65536, 65536}, '{32767, 32767, 32767, 32767},
      1, 32767, S_SAT},
    '{M_LIN, 3'd4, '{131071, 1, 65536, 40000}, '{-32768, 1000, -900, 32767}, 0, 0, S_OK},
    '{M_LSE, 3'd4, '{65536, 65536, 65536, 65536}, '{500, 500, 500, 500}, 0, 0, S_OK},
    '{M_LSE, 3'd4, '{0, 65536, 131071, 65536}, '{9000, -200, -300, -250}, 0, 0, S_OK},
    '{2'd3, 3'd4, '{65536, 30000, 131071, 1}, '{-100, -120, -5000, 32767}, 0, 0, S_OK},
    '{M_LSE, 3'd0, '{65536, 65536, 0, 0}, '{-700, 800, 0, 0}, 0, 0, S_OK},
    '{M_LSE, 3'd7, '{65536, 65536, 65536, 65536}, '{-700, 800, -32768, 32767}, 0, 0, S_OK},
    '{M_DOT, 3'd7, '{131071, 131071, 131071, 131071}, '{-1, -1, -1, -1}, 0, 0, S_OK}
  };

  initial begin
    lane_vec_t sc;
    weight_vec_t w;
    outcome_t tout;
    logic [1:0] md;
    logic [2:0] nm;
    int r, p, i, idle_pct;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    start = 1'b0;
    score_lane0_i = '0;
    score_lane1_i = '0;
    score_lane2_i = '0;
    score_lane3_i = '0;
    cur_mode = M_LSE;
    cur_models = 3'd1;
    cur_w = '{17'd65536, 17'd0, 17'd0, 17'd0};
    errors = 0;
    quiet_cycles = 0;
    use_typed = 0;
    typed_out.score = '0;
    typed_out.status = S_OK;
    idle_on = 1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    md = M_LSE;
    nm = 3'd1;
    w = '{17'd65536, 17'd0, 17'd0, 17'd0};
    for (r = 0; r < dir_tbl.size(); r++) begin
      if (dir_tbl[r].mode != md || dir_tbl[r].models != nm ||
          dir_tbl[r].w[0] != w[0] || dir_tbl[r].w[1] != w[1] ||
          dir_tbl[r].w[2] != w[2] || dir_tbl[r].w[3] != w[3]) begin
        md = dir_tbl[r].mode;
        nm = dir_tbl[r].models;
        for (i = 0; i < 4; i++) w[i] = dir_tbl[r].w[i];
        @(negedge clk_i) start <= 1'b0;
        program_regs(md, nm, w);
      end
      for (i = 0; i < 4; i++) sc[i] = dir_tbl[r].s[i];
      tout.score = dir_tbl[r].exp_score[15:0];
      tout.status = dir_tbl[r].exp_status;
      send_item(sc, dir_tbl[r].typed, tout);
    end
    @(negedge clk_i) start <= 1'b0;
    use_typed = 0;

    for (p = 0; p < RAND_PHASES; p++) begin
      idle_on = (p != RAND_PHASES - 1);
      idle_pct = $urandom_range(0, 2);
      md = 2'($urandom_range(0, 3));
      nm = 3'($urandom_range(0, 7));
      for (i = 0; i < 4; i++) w[i] = pick_weight();
      program_regs(md, nm, w);
      for (r = 0; r < PHASE_ITEMS; r++) begin
        if (idle_pct == 0) idle_on = 0;
        send_item(pick_scores(), 1'b0, tout);
      end
      @(negedge clk_i) start <= 1'b0;
    end

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
